// ===== rtl/core/miller_rabin_prime_test_macros.svh =====
// Assertion macros used by the Miller-Rabin prime test controller.
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define MRPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the asynchronous reset.
`define MRPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mrpt_pkg.sv =====
// Package with the types, codes and constant tables of the Miller-Rabin prime test.
package mrpt_pkg;

	localparam int CAND_BITS = 64;

	localparam logic [5:0] SMALL_PRIMES [0:11] = '{
		6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
	};

	// Residues of 2^16, 2^32 and 2^48 fold the candidate into a short sum for each small prime.
	localparam logic [5:0] FOLD_C1 [0:11] = '{
		6'd0, 6'd1, 6'd1, 6'd2, 6'd9, 6'd3, 6'd1, 6'd5, 6'd9, 6'd25, 6'd2, 6'd9
	};

	localparam logic [5:0] FOLD_C2 [0:11] = '{
		6'd0, 6'd1, 6'd1, 6'd4, 6'd4, 6'd9, 6'd1, 6'd6, 6'd12, 6'd16, 6'd4, 6'd7
	};

	localparam logic [5:0] FOLD_C3 [0:11] = '{
		6'd0, 6'd1, 6'd1, 6'd1, 6'd3, 6'd1, 6'd1, 6'd11, 6'd16, 6'd23, 6'd8, 6'd26
	};

	localparam logic [31:0] TRIAL_RECIP [0:11] = '{
		32'd2147483648, 32'd1431655766, 32'd858993460, 32'd613566757,
		32'd390451573, 32'd330382100, 32'd252645136, 32'd226050911,
		32'd186737709, 32'd148102321, 32'd138547333, 32'd116080198
	};

	localparam logic [31:0] WITNESS_BASES [0:6] = '{
		32'd2, 32'd325, 32'd9375, 32'd28178, 32'd450775, 32'd9780504, 32'd1795265022
	};

	localparam logic [2:0] WITNESS_LAST = 3'd6;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_TRIAL,
		OP_TRED,
		OP_CTZ,
		OP_AMOD_INIT,
		OP_AMOD,
		OP_PINIT,
		OP_MSTART_XB,
		OP_MSTART_BB,
		OP_MSTART_XX,
		OP_MSTEP,
		OP_ESHIFT,
		OP_RINIT,
		OP_RINC,
		OP_WNEXT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic d_odd;
		logic b_last;
		logic a_zero;
		logic e_zero;
		logic e_lsb;
		logic x_one;
		logic x_nm1;
		logic r_lt_s;
		logic w_last;
		logic n_lt2;
		logic small_hit;
		logic small_eq;
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TRIAL,
		S_TRED,
		S_CHECK,
		S_CTZ,
		S_WSTART,
		S_AMOD,
		S_ACHK,
		S_PLOOP,
		S_MUL1,
		S_PSQ,
		S_MUL2,
		S_PSHIFT,
		S_PCHK,
		S_RLOOP,
		S_MUL3,
		S_RCHK,
		S_WNEXT,
		S_FINISH
	} state_t;

endpackage

// ===== rtl/core/mrpt_cand_if.sv =====
// Handshake channels carrying the candidate and the prime verdict.
interface mrpt_cand_if;
	import mrpt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CAND_BITS-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_flag_if;
	logic valid;
	logic ready;
	logic prime_flag;

	modport source (output valid, output prime_flag, input ready);
	modport sink (input valid, input prime_flag, output ready);
endinterface

// ===== rtl/core/mrpt_dp.sv =====
// Datapath of the prime test: trial residues, witness reduction and the modular multiplier.
module mrpt_dp #(
	parameter int WORD_BITS = 64
) (
	input  logic                            clk,
	input  mrpt_pkg::cmd_t                  cmd,
	input  logic [mrpt_pkg::CAND_BITS-1:0]  candidate,
	output mrpt_pkg::status_t               status
);
	import mrpt_pkg::*;

	localparam int IW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] n_q, nm1_q, d_q, e_q, base_q, x_q, mx_q, my_q, macc_q;
	logic [IW-1:0]        cnt_q, s_q, r_q;
	logic [4:0]           bcnt_q;
	logic [2:0]           widx_q;
	logic                 mdst_q;
	logic [23:0]          fold_q [0:11];
	logic [5:0]           res_q [0:11];

	logic [WORD_BITS-1:0] macc_dbl, macc_next, amod_next;
	logic [WORD_BITS:0]   amod_t;
	logic [CAND_BITS-1:0] n_ext;
	logic [23:0]          trial_fold [0:11];
	logic [55:0]          trial_prod [0:11];
	logic [23:0]          trial_rem [0:11];
	logic                 hit, eq;

	function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] m);
		logic [WORD_BITS-1:0] gap;
		begin
			gap = m - b;
			if (a >= gap) begin
				add_mod = a - gap;
			end else begin
				add_mod = a + b;
			end
		end
	endfunction

	always_comb begin
		macc_dbl = add_mod(macc_q, macc_q, n_q);
		macc_next = my_q[cnt_q] ? add_mod(macc_dbl, mx_q, n_q) : macc_dbl;
		amod_t = {base_q, WITNESS_BASES[widx_q][bcnt_q]};
		if (amod_t >= {1'b0, n_q}) begin
			amod_t = amod_t - {1'b0, n_q};
		end
		amod_next = amod_t[WORD_BITS-1:0];
		n_ext = CAND_BITS'(n_q);
		hit = 1'b0;
		eq = 1'b0;
		for (int i = 0; i < 12; i++) begin
			trial_fold[i] = 24'(n_ext[15:0]) + 24'(n_ext[31:16]) * 24'(FOLD_C1[i])
				+ 24'(n_ext[47:32]) * 24'(FOLD_C2[i]) + 24'(n_ext[63:48]) * 24'(FOLD_C3[i]);
			trial_prod[i] = 56'(fold_q[i]) * 56'(TRIAL_RECIP[i]);
			trial_rem[i] = fold_q[i] - trial_prod[i][55:32] * 24'(SMALL_PRIMES[i]);
			if (res_q[i] == 6'd0) begin
				hit = 1'b1;
			end
			if (n_q == {{(WORD_BITS-6){1'b0}}, SMALL_PRIMES[i]}) begin
				eq = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				n_q <= candidate[WORD_BITS-1:0];
				nm1_q <= candidate[WORD_BITS-1:0] - {{(WORD_BITS-1){1'b0}}, 1'b1};
				d_q <= candidate[WORD_BITS-1:0] - {{(WORD_BITS-1){1'b0}}, 1'b1};
				s_q <= '0;
				widx_q <= '0;
			end
			OP_TRIAL: begin
				for (int i = 0; i < 12; i++) begin
					fold_q[i] <= trial_fold[i];
				end
			end
			OP_TRED: begin
				for (int i = 0; i < 12; i++) begin
					res_q[i] <= trial_rem[i][5:0];
				end
			end
			OP_CTZ: begin
				d_q <= d_q >> 1;
				s_q <= s_q + IW'(1);
			end
			OP_AMOD_INIT: begin
				base_q <= '0;
				bcnt_q <= 5'd31;
			end
			OP_AMOD: begin
				base_q <= amod_next;
				bcnt_q <= bcnt_q - 5'd1;
			end
			OP_PINIT: begin
				x_q <= {{(WORD_BITS-1){1'b0}}, 1'b1};
				e_q <= d_q;
			end
			OP_MSTART_XB: begin
				mx_q <= x_q;
				my_q <= base_q;
				macc_q <= '0;
				mdst_q <= 1'b0;
				cnt_q <= IW'(WORD_BITS - 1);
			end
			OP_MSTART_BB: begin
				mx_q <= base_q;
				my_q <= base_q;
				macc_q <= '0;
				mdst_q <= 1'b1;
				cnt_q <= IW'(WORD_BITS - 1);
			end
			OP_MSTART_XX: begin
				mx_q <= x_q;
				my_q <= x_q;
				macc_q <= '0;
				mdst_q <= 1'b0;
				cnt_q <= IW'(WORD_BITS - 1);
			end
			OP_MSTEP: begin
				macc_q <= macc_next;
				cnt_q <= cnt_q - IW'(1);
				if (cnt_q == '0) begin
					if (mdst_q) begin
						base_q <= macc_next;
					end else begin
						x_q <= macc_next;
					end
				end
			end
			OP_ESHIFT: begin
				e_q <= e_q >> 1;
			end
			OP_RINIT: begin
				r_q <= IW'(1);
			end
			OP_RINC: begin
				r_q <= r_q + IW'(1);
			end
			OP_WNEXT: begin
				widx_q <= widx_q + 3'd1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.cnt_last = (cnt_q == '0);
		status.d_odd = d_q[0];
		status.b_last = (bcnt_q == 5'd0);
		status.a_zero = (base_q == '0);
		status.e_zero = (e_q == '0);
		status.e_lsb = e_q[0];
		status.x_one = (x_q == {{(WORD_BITS-1){1'b0}}, 1'b1});
		status.x_nm1 = (x_q == nm1_q);
		status.r_lt_s = (r_q < s_q);
		status.w_last = (widx_q == WITNESS_LAST);
		status.n_lt2 = (n_q[WORD_BITS-1:1] == '0);
		status.small_hit = hit;
		status.small_eq = eq;
	end

endmodule

// ===== rtl/core/mrpt_ctrl.sv =====
// Controller state machine sequencing the prime test and holding the verdict register.
module mrpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              rsp_flag,
	input  mrpt_pkg::status_t status,
	output mrpt_pkg::cmd_t    cmd
);
	import mrpt_pkg::*;

	state_t state_q, state_d;
	logic   verdict_q, verdict_d, verdict_set;
	logic   out_valid_q, flag_q, out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			verdict_q <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (verdict_set) begin
				verdict_q <= verdict_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				flag_q <= verdict_q;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		req_ready = 1'b0;
		verdict_set = 1'b0;
		verdict_d = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op = OP_LOAD;
					state_d = S_TRIAL;
				end
			end
			S_TRIAL: begin
				cmd.op = OP_TRIAL;
				state_d = S_TRED;
			end
			S_TRED: begin
				cmd.op = OP_TRED;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (status.n_lt2) begin
					verdict_set = 1'b1;
					state_d = S_FINISH;
				end else if (status.small_hit) begin
					verdict_set = 1'b1;
					verdict_d = status.small_eq;
					state_d = S_FINISH;
				end else begin
					state_d = S_CTZ;
				end
			end
			S_CTZ: begin
				if (status.d_odd) begin
					state_d = S_WSTART;
				end else begin
					cmd.op = OP_CTZ;
				end
			end
			S_WSTART: begin
				cmd.op = OP_AMOD_INIT;
				state_d = S_AMOD;
			end
			S_AMOD: begin
				cmd.op = OP_AMOD;
				if (status.b_last) begin
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				if (status.a_zero) begin
					state_d = S_WNEXT;
				end else begin
					cmd.op = OP_PINIT;
					state_d = S_PLOOP;
				end
			end
			S_PLOOP: begin
				if (status.e_zero) begin
					state_d = S_PCHK;
				end else if (status.e_lsb) begin
					cmd.op = OP_MSTART_XB;
					state_d = S_MUL1;
				end else begin
					cmd.op = OP_MSTART_BB;
					state_d = S_MUL2;
				end
			end
			S_MUL1: begin
				cmd.op = OP_MSTEP;
				if (status.cnt_last) begin
					state_d = S_PSQ;
				end
			end
			S_PSQ: begin
				cmd.op = OP_MSTART_BB;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op = OP_MSTEP;
				if (status.cnt_last) begin
					state_d = S_PSHIFT;
				end
			end
			S_PSHIFT: begin
				cmd.op = OP_ESHIFT;
				state_d = S_PLOOP;
			end
			S_PCHK: begin
				if (status.x_one || status.x_nm1) begin
					state_d = S_WNEXT;
				end else begin
					cmd.op = OP_RINIT;
					state_d = S_RLOOP;
				end
			end
			S_RLOOP: begin
				if (status.r_lt_s) begin
					cmd.op = OP_MSTART_XX;
					state_d = S_MUL3;
				end else begin
					verdict_set = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_MUL3: begin
				cmd.op = OP_MSTEP;
				if (status.cnt_last) begin
					state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				if (status.x_nm1) begin
					state_d = S_WNEXT;
				end else begin
					cmd.op = OP_RINC;
					state_d = S_RLOOP;
				end
			end
			S_WNEXT: begin
				if (status.w_last) begin
					verdict_set = 1'b1;
					verdict_d = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.op = OP_WNEXT;
					state_d = S_WSTART;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp_flag = flag_q;

`include "miller_rabin_prime_test_macros.svh"

	`MRPT_ASSERT_NEXT(a_accept_starts_trial, req_valid && req_ready, state_q == S_TRIAL, "Accepted candidate did not start trial division.")
	`MRPT_ASSERT_NOW(a_mstep_in_mul, cmd.op == OP_MSTEP, state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3, "Multiplier step issued outside a multiply state.")
	`MRPT_ASSERT_NOW(a_load_when_free, out_load, !out_valid_q || rsp_ready, "Verdict register overwritten before its transfer.")
	`MRPT_ASSERT_NEXT(a_finish_sets_valid, state_q == S_FINISH && state_d == S_IDLE, out_valid_q, "Finished verdict was not presented.")

endmodule

// ===== rtl/core/miller_rabin_prime_test.sv =====
// Top level of the deterministic Miller-Rabin prime test.
//
// Channel  Role    Payload
// req      sink    candidate, 64 bits, unsigned
// rsp      source  prime_flag, 1 bit
//
// One candidate is tested at a time; req.ready is high only while the controller is idle.
// Each modular product is formed by the shared shift-and-add multiplier.
// A candidate settled by a small prime presents its verdict after the trial, reduction and check states,
// otherwise after the witness rounds, whose length is set by the multiplier loop.
// Reset clears the controller and the verdict register; a stalled rsp holds the verdict
// while the next candidate may already be accepted and tested.
module miller_rabin_prime_test #(
	parameter int WORD_BITS = 64
) (
	input logic        clk,
	input logic        arst_n,
	mrpt_cand_if.sink  req,
	mrpt_flag_if.source rsp
);
	import mrpt_pkg::*;

	cmd_t    cmd;
	status_t status;

	mrpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_flag  (rsp.prime_flag),
		.status    (status),
		.cmd       (cmd)
	);

	mrpt_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.candidate (req.candidate),
		.status    (status)
	);

endmodule
